// File: rtl/ipu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipu_pkg
// Types, constants and per-stage arithmetic of the point undistortion pipe.
// ----------------------------------------------------------------------------
package ipu_pkg;

    localparam int ITERATIONS  = 5;
    localparam int DIV_BITS    = 32;
    localparam int NORM_STAGES = 3;
    localparam int ITER_STAGES = 7 + DIV_BITS + 2;
    localparam int HOMO_STAGES = 3 + DIV_BITS + 1;
    localparam int ITER_END    = NORM_STAGES + ITERATIONS * ITER_STAGES;
    localparam int NUM_STAGES  = ITER_END + HOMO_STAGES;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_COEFS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M00_M01    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_M02_M10    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_M11_M12    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_M20_M21    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_M22        = 4'd7;

    localparam logic [63:0] RST_INV_FOCAL = 64'h0100_0000_0100_0000;
    localparam logic [63:0] RST_DIAG_ONE  = 64'h0001_0000_0000_0000;
    localparam logic [31:0] RST_M22       = 32'h0001_0000;

    // normalize phases
    localparam int NP_SUB = 0;
    localparam int NP_MUL = 1;
    localparam int NP_SAT = 2;
    // iteration phases
    localparam int PH_SQ    = 0;
    localparam int PH_SUM   = 1;
    localparam int PH_COEF  = 2;
    localparam int PH_DIST  = 3;
    localparam int PH_TR    = 4;
    localparam int PH_DEN   = 5;
    localparam int PH_SETUP = 6;
    localparam int PH_DIV0  = 7;
    localparam int PH_FIN   = PH_DIV0 + DIV_BITS;
    localparam int PH_UPD   = PH_FIN + 1;
    // homography phases
    localparam int HP_MUL   = 0;
    localparam int HP_SUM   = 1;
    localparam int HP_SETUP = 2;
    localparam int HP_DIV0  = 3;
    localparam int HP_OUT   = HP_DIV0 + DIV_BITS;

    typedef enum logic [1:0] {
        SEG_NORM,
        SEG_ITER,
        SEG_HOMO
    } seg_t;

    typedef logic signed [47:0] wide_t;
    typedef logic signed [31:0] q28_t;

    localparam q28_t  Q_MAX  = 32'sh7FFF_FFFF;
    localparam q28_t  Q_MIN  = 32'sh8000_0000;
    localparam wide_t W_MAX  = 48'sd2147483647;
    localparam wide_t W_MIN  = -48'sd2147483648;
    localparam wide_t W_ONE  = 48'sd268435456;
    localparam logic [39:0] RECIP_HI = 40'h00_0100_0000;

    typedef struct packed {
        logic [31:0] ifx;
        logic [31:0] ify;
        logic [31:0] cx;
        logic [31:0] cy;
        q28_t        k1;
        q28_t        k2;
        q28_t        p1;
        q28_t        p2;
        q28_t        m00;
        q28_t        m01;
        q28_t        m02;
        q28_t        m10;
        q28_t        m11;
        q28_t        m12;
        q28_t        m20;
        q28_t        m21;
        q28_t        m22;
    } cfg_t;

    typedef struct packed {
        q28_t        x0;
        q28_t        y0;
        q28_t        x;
        q28_t        y;
        wide_t       a;
        wide_t       b;
        wide_t       c;
        wide_t       d;
        wide_t       e;
        wide_t       f;
        logic [39:0] rem;
        logic [39:0] rem2;
        logic [39:0] dvs;
        logic [31:0] num;
        logic [31:0] num2;
        logic [31:0] quo;
        logic [31:0] quo2;
        logic        neg;
        logic        neg2;
        logic        ovf;
        logic        ovf2;
        logic        zero;
        logic        flag;
    } pl_t;

    function automatic logic ovf32(wide_t v);
        return (v > W_MAX) || (v < W_MIN);
    endfunction

    function automatic q28_t sat32(wide_t v);
        if (v > W_MAX)
            return Q_MAX;
        else if (v < W_MIN)
            return Q_MIN;
        return v[31:0];
    endfunction

    // a*b/2^28, round half up
    function automatic wide_t mul28(q28_t a, q28_t b);
        logic signed [63:0] pr;
        pr = 64'(a) * 64'(b);
        return 48'((pr + 64'sd134217728) >>> 28);
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [40:0] div_step(logic [39:0] rem, logic [39:0] dvs, logic nb);
        logic [40:0] r;
        logic        ge;
        r  = {rem, nb};
        ge = (r >= {1'b0, dvs});
        return {ge, ge ? 40'(r - {1'b0, dvs}) : r[39:0]};
    endfunction

    // {flag, value}: signed, saturated quotient
    function automatic logic [32:0] fin_div(logic [31:0] q, logic ovf, logic neg);
        logic signed [33:0] v;
        v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        if (ovf)
            return {1'b1, neg ? Q_MIN : Q_MAX};
        return {ovf32(48'(v)), sat32(48'(v))};
    endfunction

    function automatic pl_t stage_next(seg_t seg, int ph, pl_t p, cfg_t c);
        pl_t                n;
        logic signed [32:0] dxs;
        logic signed [32:0] dys;
        logic [63:0]        prx;
        logic [63:0]        pry;
        wide_t              w1;
        wide_t              w2;
        wide_t              w3;
        q28_t               r2;
        logic [32:0]        mag;
        logic [37:0]        wm;
        logic [36:0]        nmx;
        logic [36:0]        nmy;
        logic [63:0]        numx;
        logic [63:0]        numy;
        logic [40:0]        dr;
        logic [40:0]        dr2;
        logic [32:0]        fx;
        logic [32:0]        fy;
        n = p;
        case (seg)
            SEG_NORM:
            begin
                case (ph)
                    NP_SUB:
                    begin
                        dxs    = $signed({1'b0, p.x0}) - $signed({1'b0, c.cx});
                        dys    = $signed({1'b0, p.y0}) - $signed({1'b0, c.cy});
                        n.neg  = dxs[32];
                        n.neg2 = dys[32];
                        n.a    = 48'(dxs[32] ? -dxs : dxs);
                        n.b    = 48'(dys[32] ? -dys : dys);
                        n.flag = 1'b0;
                        n.zero = 1'b0;
                    end
                    NP_MUL:
                    begin
                        prx = 64'(p.a[32:0]) * 64'(c.ifx);
                        pry = 64'(p.b[32:0]) * 64'(c.ify);
                        n.a = 48'((prx + 64'd524288) >> 20);
                        n.b = 48'((pry + 64'd524288) >> 20);
                    end
                    NP_SAT:
                    begin
                        w1     = p.neg ? -p.a : p.a;
                        w2     = p.neg2 ? -p.b : p.b;
                        n.x0   = sat32(w1);
                        n.y0   = sat32(w2);
                        n.x    = sat32(w1);
                        n.y    = sat32(w2);
                        n.flag = p.flag | ovf32(w1) | ovf32(w2);
                    end
                    default:
                    begin
                        n = p;
                    end
                endcase
            end
            SEG_ITER:
            begin
                case (ph) inside
                    PH_SQ:
                    begin
                        w1     = mul28(p.x, p.x);
                        w2     = mul28(p.y, p.y);
                        w3     = mul28(p.x, p.y);
                        n.a    = 48'(sat32(w1));
                        n.b    = 48'(sat32(w2));
                        n.c    = 48'(sat32(w3));
                        n.flag = p.flag | ovf32(w1) | ovf32(w2) | ovf32(w3);
                    end
                    PH_SUM:
                    begin
                        w1     = p.a + p.b;
                        r2     = sat32(w1);
                        w2     = 48'(r2) + (p.a <<< 1);
                        w3     = 48'(r2) + (p.b <<< 1);
                        n.a    = 48'(r2);
                        n.b    = 48'(sat32(w2));
                        n.e    = 48'(sat32(w3));
                        n.flag = p.flag | ovf32(w1) | ovf32(w2) | ovf32(w3);
                    end
                    PH_COEF:
                    begin
                        n.b = mul28(c.k2, p.a[31:0]);
                        n.c = mul28(c.p1, p.c[31:0]);
                        n.d = mul28(c.p2, p.b[31:0]);
                        n.e = mul28(c.p1, p.e[31:0]);
                        n.f = mul28(c.p2, p.c[31:0]);
                    end
                    PH_DIST:
                    begin
                        w1     = p.b + 48'(c.k1);
                        w2     = (p.c <<< 1) + p.d;
                        w3     = p.e + (p.f <<< 1);
                        n.b    = 48'(sat32(w1));
                        n.c    = 48'(sat32(w2));
                        n.d    = 48'(sat32(w3));
                        n.flag = p.flag | ovf32(w1) | ovf32(w2) | ovf32(w3);
                    end
                    PH_TR:
                    begin
                        n.b = mul28(p.b[31:0], p.a[31:0]);
                    end
                    PH_DEN:
                    begin
                        w1     = W_ONE + p.b;
                        w2     = 48'(p.x0) - p.c;
                        w3     = 48'(p.y0) - p.d;
                        n.a    = 48'(sat32(w1));
                        n.c    = 48'(sat32(w2));
                        n.d    = 48'(sat32(w3));
                        n.flag = p.flag | ovf32(w1) | ovf32(w2) | ovf32(w3);
                    end
                    PH_SETUP:
                    begin
                        // 2^56 + |den|/2 over |den|; a zero divisor shows as overflow
                        mag   = p.a[47] ? 33'(-p.a) : 33'(p.a);
                        n.neg = p.a[47];
                        n.dvs = 40'(mag);
                        n.rem = RECIP_HI;
                        n.num = mag[32:1];
                        n.ovf = (RECIP_HI >= 40'(mag));
                        n.quo = '0;
                    end
                    [PH_DIV0:PH_FIN-1]:
                    begin
                        dr    = div_step(p.rem, p.dvs, p.num[31]);
                        n.rem = dr[39:0];
                        n.quo = {p.quo[30:0], dr[40]};
                        n.num = {p.num[30:0], 1'b0};
                    end
                    PH_FIN:
                    begin
                        fx     = fin_div(p.quo, p.ovf, p.neg);
                        n.a    = 48'($signed(fx[31:0]));
                        n.flag = p.flag | fx[32];
                    end
                    PH_UPD:
                    begin
                        w1     = mul28(p.c[31:0], p.a[31:0]);
                        w2     = mul28(p.d[31:0], p.a[31:0]);
                        n.x    = sat32(w1);
                        n.y    = sat32(w2);
                        n.flag = p.flag | ovf32(w1) | ovf32(w2);
                    end
                    default:
                    begin
                        n = p;
                    end
                endcase
            end
            SEG_HOMO:
            begin
                case (ph) inside
                    HP_MUL:
                    begin
                        n.a = mul28(c.m00, p.x);
                        n.b = mul28(c.m01, p.y);
                        n.c = mul28(c.m10, p.x);
                        n.d = mul28(c.m11, p.y);
                        n.e = mul28(c.m20, p.x);
                        n.f = mul28(c.m21, p.y);
                    end
                    HP_SUM:
                    begin
                        n.a = p.a + p.b + 48'(c.m02);
                        n.c = p.c + p.d + 48'(c.m12);
                        n.e = p.e + p.f + 48'(c.m22);
                    end
                    HP_SETUP:
                    begin
                        wm     = p.e[47] ? 38'(-p.e) : 38'(p.e);
                        nmx    = p.a[47] ? 37'(-p.a) : 37'(p.a);
                        nmy    = p.c[47] ? 37'(-p.c) : 37'(p.c);
                        numx   = (64'(nmx) << 16) + 64'(wm[37:1]);
                        numy   = (64'(nmy) << 16) + 64'(wm[37:1]);
                        n.zero = (p.e == '0);
                        n.dvs  = 40'(wm);
                        n.rem  = 40'(numx[63:32]);
                        n.rem2 = 40'(numy[63:32]);
                        n.num  = numx[31:0];
                        n.num2 = numy[31:0];
                        n.ovf  = (40'(numx[63:32]) >= 40'(wm));
                        n.ovf2 = (40'(numy[63:32]) >= 40'(wm));
                        n.neg  = p.a[47] ^ p.e[47];
                        n.neg2 = p.c[47] ^ p.e[47];
                        n.quo  = '0;
                        n.quo2 = '0;
                    end
                    [HP_DIV0:HP_OUT-1]:
                    begin
                        dr     = div_step(p.rem, p.dvs, p.num[31]);
                        dr2    = div_step(p.rem2, p.dvs, p.num2[31]);
                        n.rem  = dr[39:0];
                        n.rem2 = dr2[39:0];
                        n.quo  = {p.quo[30:0], dr[40]};
                        n.quo2 = {p.quo2[30:0], dr2[40]};
                        n.num  = {p.num[30:0], 1'b0};
                        n.num2 = {p.num2[30:0], 1'b0};
                    end
                    HP_OUT:
                    begin
                        fx = fin_div(p.quo, p.ovf, p.neg);
                        fy = fin_div(p.quo2, p.ovf2, p.neg2);
                        if (p.zero)
                        begin
                            n.x    = '0;
                            n.y    = '0;
                            n.flag = 1'b1;
                        end
                        else
                        begin
                            n.x    = fx[31:0];
                            n.y    = fy[31:0];
                            n.flag = p.flag | fx[32] | fy[32];
                        end
                    end
                    default:
                    begin
                        n = p;
                    end
                endcase
            end
            default:
            begin
                n = p;
            end
        endcase
        return n;
    endfunction

endpackage

// File: rtl/iterative_point_undistort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_point_undistort
// Pixel point to rectified point: normalize, iterative radial/tangential
// undistortion, then the P*R homography, all in one stall-safe pipeline.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                   transfer when
//  s_axis   in         tdata: pixel_x [31:0], pixel_y [63:32]    tvalid & tready
//  m_axis   out        tdata: out_x [31:0], out_y [63:32],       tvalid & tready
//                      tuser: degenerate [0]
//  cfg      in         cfg_index, cfg_data (register write)      cfg_valid & cfg_ready
//
//  One point per cycle unless the output stalls. Most of the NUM_STAGES
//  stages belong to the bit-per-stage restoring dividers: a 32-stage
//  reciprocal in every iteration and a 32-stage pair of dividers at the end.
//  Reset clears the stage valid bits and loads identity geometry into the
//  configuration registers. Each stage holds while the one after it is full
//  and stalled; empty stages still fill, so bubbles close up under stall.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
module iterative_point_undistort (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ipu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,   // pixel_x, pixel_y
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // out_x, out_y
    output logic [0:0]                    m_axis_tuser    // degenerate
);
    import ipu_pkg::*;

    logic [63:0] inv_focal_reg;
    logic [63:0] principal_reg;
    logic [63:0] dist_reg;
    logic [63:0] m00_m01_reg;
    logic [63:0] m02_m10_reg;
    logic [63:0] m11_m12_reg;
    logic [63:0] m20_m21_reg;
    logic [31:0] m22_reg;
    cfg_t        cfg;

    pl_t                   head;
    pl_t                   pipe [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld;
    logic [NUM_STAGES:0]   rdy;

    // ---- configuration ----------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_reg <= RST_INV_FOCAL;
            principal_reg <= '0;
            dist_reg      <= '0;
            m00_m01_reg   <= RST_DIAG_ONE;
            m02_m10_reg   <= '0;
            m11_m12_reg   <= RST_DIAG_ONE;
            m20_m21_reg   <= '0;
            m22_reg       <= RST_M22;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INV_FOCAL:  inv_focal_reg <= cfg_data;
                REG_PRINCIPAL:  principal_reg <= cfg_data;
                REG_DIST_COEFS: dist_reg      <= cfg_data;
                REG_M00_M01:    m00_m01_reg   <= cfg_data;
                REG_M02_M10:    m02_m10_reg   <= cfg_data;
                REG_M11_M12:    m11_m12_reg   <= cfg_data;
                REG_M20_M21:    m20_m21_reg   <= cfg_data;
                REG_M22:        m22_reg       <= cfg_data[31:0];
                default:        ;  // unmapped index: dropped
            endcase
        end
    end

    // Q2.14 coefficients widen to Q4.28
    always_comb
    begin
        cfg.ifx = inv_focal_reg[63:32];
        cfg.ify = inv_focal_reg[31:0];
        cfg.cx  = principal_reg[63:32];
        cfg.cy  = principal_reg[31:0];
        cfg.k1  = {{2{dist_reg[63]}}, dist_reg[63:48], 14'b0};
        cfg.k2  = {{2{dist_reg[47]}}, dist_reg[47:32], 14'b0};
        cfg.p1  = {{2{dist_reg[31]}}, dist_reg[31:16], 14'b0};
        cfg.p2  = {{2{dist_reg[15]}}, dist_reg[15:0], 14'b0};
        cfg.m00 = m00_m01_reg[63:32];
        cfg.m01 = m00_m01_reg[31:0];
        cfg.m02 = m02_m10_reg[63:32];
        cfg.m10 = m02_m10_reg[31:0];
        cfg.m11 = m11_m12_reg[63:32];
        cfg.m12 = m11_m12_reg[31:0];
        cfg.m20 = m20_m21_reg[63:32];
        cfg.m21 = m20_m21_reg[31:0];
        cfg.m22 = m22_reg;
    end

    // ---- pipeline ---------------------------------------------------------
    // raw pixels enter in x0/y0; the first stage turns them into offsets
    always_comb
    begin
        head    = '0;
        head.x0 = s_axis_tdata[31:0];
        head.y0 = s_axis_tdata[63:32];
    end

    assign rdy[NUM_STAGES] = m_axis_tready;
    assign s_axis_tready   = rdy[0];

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        localparam seg_t SEG = (g < NORM_STAGES) ? SEG_NORM :
                               (g < ITER_END)    ? SEG_ITER : SEG_HOMO;
        localparam int   PH  = (g < NORM_STAGES) ? g :
                               (g < ITER_END)    ? (g - NORM_STAGES) % ITER_STAGES :
                                                   g - ITER_END;
        logic v_reg;
        pl_t  d_reg;
        pl_t  d_next;
        logic v_in;

        if (g == 0)
        begin : g_first
            assign v_in   = s_axis_tvalid;
            assign d_next = stage_next(SEG, PH, head, cfg);
        end
        else
        begin : g_rest
            assign v_in   = vld[g-1];
            assign d_next = stage_next(SEG, PH, pipe[g-1], cfg);
        end

        // a stage takes new data when empty or when its content moves on
        assign rdy[g]  = ~v_reg | rdy[g+1];
        assign vld[g]  = v_reg;
        assign pipe[g] = d_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (rdy[g])
                v_reg <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g] && v_in)
                d_reg <= d_next;
        end
    end

    assign m_axis_tvalid   = vld[NUM_STAGES-1];
    assign m_axis_tdata    = {pipe[NUM_STAGES-1].y, pipe[NUM_STAGES-1].x};
    assign m_axis_tuser[0] = pipe[NUM_STAGES-1].flag;

    // ---- checks -----------------------------------------------------------
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && pipe[NUM_STAGES-1].zero |->
            (m_axis_tdata == '0) && m_axis_tuser[0])
        else $error("zero denominator result not cleared and flagged");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[0] |-> s_axis_tready)
        else $error("empty first stage refuses input");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld[NUM_STAGES-2] && vld[NUM_STAGES-1] && !m_axis_tready |=>
            vld[NUM_STAGES-2])
        else $error("item lost behind stalled output");

endmodule

// File: verif/iterative_point_undistort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_point_undistort_checker
// Watches the register, input and result channels. For every accepted pixel
// it computes the rectified point and the degenerate flag, queues them, and
// compares each accepted result with the oldest queued point.
// ----------------------------------------------------------------------------
module iterative_point_undistort_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ipu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [63:0]                   m_axis_tdata,
    input  logic [0:0]                    m_axis_tuser,
    output int                            errors,
    output int                            pending
);
    import ipu_pkg::*;

    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;
    localparam longint ONE_28 = 64'sd268435456;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic        deg;
    } point_t;

    logic [63:0] shadow [8];
    point_t      rectified_q [$];

    assign pending = rectified_q.size();

    function automatic longint clamp32(longint v, inout bit f);
        if (v > LIM_HI)
        begin
            f = 1'b1;
            return LIM_HI;
        end
        if (v < LIM_LO)
        begin
            f = 1'b1;
            return LIM_LO;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd134217728) >>> 28;
    endfunction

    function automatic longint norm_axis(logic [31:0] pix, logic [31:0] ctr,
                                         logic [31:0] inv, inout bit f);
        longint      d;
        logic [63:0] m;
        longint      r;
        d = longint'({32'd0, pix}) - longint'({32'd0, ctr});
        m = 64'(d < 0 ? -d : d) * {32'd0, inv};
        r = longint'((m + 64'd524288) >> 20);
        return clamp32(d < 0 ? -r : r, f);
    endfunction

    function automatic longint recip_q28(longint den, inout bit f);
        longint mag;
        if (den == 0)
        begin
            f = 1'b1;
            return LIM_HI;
        end
        mag = den < 0 ? -den : den;
        return clamp32(den < 0 ? -(((64'sd1 <<< 56) + mag / 2) / mag)
                               : (((64'sd1 <<< 56) + mag / 2) / mag), f);
    endfunction

    function automatic longint quot16(longint n, longint w, inout bit f);
        longint nm;
        longint wm;
        longint q;
        nm = n < 0 ? -n : n;
        wm = w < 0 ? -w : w;
        q  = ((nm <<< 16) + wm / 2) / wm;
        if (q > (64'sd1 <<< 32))
            q = 64'sd1 <<< 32;
        return clamp32(((n < 0) != (w < 0)) ? -q : q, f);
    endfunction

    function automatic point_t undistort_point(logic [31:0] px, logic [31:0] py);
        bit     f;
        longint k1, k2, p1, p2;
        longint m [9];
        longint x, y, x0, y0, xx, yy, xy, r2, t, den, ic, dx, dy, nx, ny, w;
        point_t res;
        f  = 1'b0;
        k1 = longint'($signed(shadow[2][63:48])) * 16384;
        k2 = longint'($signed(shadow[2][47:32])) * 16384;
        p1 = longint'($signed(shadow[2][31:16])) * 16384;
        p2 = longint'($signed(shadow[2][15:0])) * 16384;
        for (int i = 0; i < 4; i++)
        begin
            m[2*i]   = longint'($signed(shadow[3+i][63:32]));
            m[2*i+1] = longint'($signed(shadow[3+i][31:0]));
        end
        m[8] = longint'($signed(shadow[7][31:0]));
        x  = norm_axis(px, shadow[1][63:32], shadow[0][63:32], f);
        y  = norm_axis(py, shadow[1][31:0], shadow[0][31:0], f);
        x0 = x;
        y0 = y;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            xx  = clamp32(qmul(x, x), f);
            yy  = clamp32(qmul(y, y), f);
            xy  = clamp32(qmul(x, y), f);
            r2  = clamp32(xx + yy, f);
            t   = clamp32(qmul(k2, r2) + k1, f);
            den = clamp32(ONE_28 + qmul(t, r2), f);
            ic  = recip_q28(den, f);
            dx  = clamp32(2 * qmul(p1, xy) + qmul(p2, clamp32(r2 + 2 * xx, f)), f);
            dy  = clamp32(qmul(p1, clamp32(r2 + 2 * yy, f)) + 2 * qmul(p2, xy), f);
            x   = clamp32(qmul(clamp32(x0 - dx, f), ic), f);
            y   = clamp32(qmul(clamp32(y0 - dy, f), ic), f);
        end
        nx = qmul(m[0], x) + qmul(m[1], y) + m[2];
        ny = qmul(m[3], x) + qmul(m[4], y) + m[5];
        w  = qmul(m[6], x) + qmul(m[7], y) + m[8];
        if (w == 0)
        begin
            f      = 1'b1;
            res.ox = '0;
            res.oy = '0;
        end
        else
        begin
            res.ox = 32'(quot16(nx, w, f));
            res.oy = 32'(quot16(ny, w, f));
        end
        res.deg = f;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            errors = 0;
            shadow[REG_INV_FOCAL]  <= RST_INV_FOCAL;
            shadow[REG_PRINCIPAL]  <= '0;
            shadow[REG_DIST_COEFS] <= '0;
            shadow[REG_M00_M01]    <= RST_DIAG_ONE;
            shadow[REG_M02_M10]    <= '0;
            shadow[REG_M11_M12]    <= RST_DIAG_ONE;
            shadow[REG_M20_M21]    <= '0;
            shadow[REG_M22]        <= {32'd0, RST_M22};
        end
        else
        begin
            // registers must only be written while the pipe is empty; nothing here enforces it
            if (cfg_valid && cfg_ready && cfg_index <= REG_M22)
                shadow[cfg_index[2:0]] <= (cfg_index == REG_M22) ? {32'd0, cfg_data[31:0]}
                                                                 : cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                rectified_q.push_back(undistort_point(s_axis_tdata[31:0],
                                                      s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rectified_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result with nothing expected: x=%h y=%h deg=%b",
                                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
                end
                else
                begin
                    want = rectified_q.pop_front();
                    if (want.ox !== m_axis_tdata[31:0] || want.oy !== m_axis_tdata[63:32]
                        || want.deg !== m_axis_tuser[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp x=%h y=%h deg=%b got x=%h y=%h deg=%b",
                                     want.ox, want.oy, want.deg, m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tuser);
                    end
                end
            end
        end
    end

endmodule

// File: verif/iterative_point_undistort_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_point_undistort_test
// Drives the undistortion pipe through a series of register settings:
// reset geometry, the singular lens and homography cases, unmapped indexes,
// all-zero, all-one and random registers, and camera setups with random
// points. Both sides idle at random; one long output stall backs up the pipe.
// ----------------------------------------------------------------------------
module iterative_point_undistort_test;
    import ipu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;     // pixel_x, pixel_y
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;     // out_x, out_y
    logic [0:0]           m_axis_tuser;     // degenerate

    int  errors;
    int  pending;
    int  cycles = 0;
    int  send_idle_pct;     // chance of an idle cycle before a point
    int  recv_idle_pct;     // chance of dropping tready on a cycle
    int  stall_len;         // length of the requested output hold-off
    int  stall_req;         // bumped to request a hold-off

    iterative_point_undistort i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    iterative_point_undistort_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("iterative_point_undistort regression: fail");
            $finish;
        end
    end

    // result side: random idling, plus a counted hold-off on request
    initial
    begin
        int seen_req;
        int hold;
        seen_req      = 0;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req != seen_req)
            begin
                seen_req = stall_req;
                hold     = stall_len;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // sender rests until every queued point has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic load_geometry(logic [63:0] ifoc, logic [63:0] pp, logic [63:0] coefs,
                                 logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                                 logic [63:0] r3, logic [31:0] m22);
        drain();
        write_reg(REG_INV_FOCAL, ifoc);
        write_reg(REG_PRINCIPAL, pp);
        write_reg(REG_DIST_COEFS, coefs);
        write_reg(REG_M00_M01, r0);
        write_reg(REG_M02_M10, r1);
        write_reg(REG_M11_M12, r2);
        write_reg(REG_M20_M21, r3);
        write_reg(REG_M22, {$urandom(), m22});   // upper word is don't-care
    endtask

    function automatic logic [31:0] small_q16(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // camera-like setup: focal 300..2000 px, modest lens, P*R near K
    task automatic load_camera;
        int          fx;
        int          fy;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [15:0] k1, k2, p1, p2;
        fx = $urandom_range(300, 2000);
        fy = $urandom_range(300, 2000);
        cx = ($urandom_range(200, 1000) << 16) | $urandom_range(16'hFFFF);
        cy = ($urandom_range(150, 700) << 16) | $urandom_range(16'hFFFF);
        k1 = 16'($signed($urandom_range(16384)) - 8192);
        k2 = 16'($signed($urandom_range(6554)) - 3277);
        p1 = 16'($signed($urandom_range(328)) - 164);
        p2 = 16'($signed($urandom_range(328)) - 164);
        load_geometry({32'((64'd1 << 32) / fx), 32'((64'd1 << 32) / fy)},
                      {cx, cy}, {k1, k2, p1, p2},
                      {32'(fx << 16) + small_q16(4000), small_q16(20000)},
                      {cx + small_q16(30000), small_q16(20000)},
                      {32'(fy << 16) + small_q16(4000), cy + small_q16(30000)},
                      {small_q16(70), small_q16(70)}, 32'h0001_0000 + small_q16(700));
    endtask

    // mostly in-image points, some anywhere in the 32-bit range
    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 80)
                send_point(($urandom_range(1300) << 16) | $urandom_range(16'hFFFF),
                           ($urandom_range(1000) << 16) | $urandom_range(16'hFFFF));
            else
                send_point($urandom(), $urandom());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 38;
        recv_idle_pct = 38;
        stall_len     = 0;
        stall_req     = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: identity, pixels divided by 256
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);      // normalizes past range
        send_point(32'h8000_0000, 32'h0000_0001);
        send_point(32'h0000_0001, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0001_0000);
        send_point(32'h07FF_FFFF, 32'h0800_0000);       // right at the Q4.28 edge
        send_point(32'h5555_5555, 32'hAAAA_AAAA);

        // k1 = -1 with r^2 = 1 makes the lens denominator zero
        load_geometry(RST_INV_FOCAL, '0, 64'hC000_0000_0000_0000,
                      RST_DIAG_ONE, '0, RST_DIAG_ONE, '0, RST_M22);
        send_point(32'h0100_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0100_0000);
        send_point(32'h00B5_0000, 32'h00B5_0000);

        // zero bottom row: homogeneous denominator zero
        load_geometry(RST_INV_FOCAL, 64'h0080_0000_0040_0000, 64'h7FFF_8000_7FFF_8000,
                      RST_DIAG_ONE, '0, RST_DIAG_ONE, '0, 32'h0000_0000);
        send_point(32'h0080_0000, 32'h0040_0000);
        send_point(32'h1234_5678, 32'h8765_4321);

        // indexes past the register file must be ignored
        drain();
        for (int idx = int'(REG_M22) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), {$urandom(), $urandom()});
        send_point(32'h0040_0000, 32'h0020_0000);

        // all-zero and all-one registers
        load_geometry('0, '0, '0, '0, '0, '0, '0, '0);
        send_point($urandom(), $urandom());
        send_point(32'hFFFF_FFFF, 32'h0000_0000);
        load_geometry('1, '1, '1, '1, '1, '1, '1, '1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_0000, 32'h0000_0000);
        random_points(6);

        // random register words, full range
        load_geometry({$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()}, $urandom());
        random_points(40);

        // back-pressure: long output hold-off while the sender never idles
        load_camera();
        send_idle_pct = 0;
        stall_len     = 600;
        stall_req++;
        random_points(400);

        // stretch with no idling on either side
        load_camera();
        recv_idle_pct = 0;
        random_points(200);
        send_idle_pct = 38;
        recv_idle_pct = 38;

        for (int ph = 0; ph < 6; ph++)
        begin
            load_camera();
            random_points(110);
        end

        drain();
        repeat (300)
            @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("iterative_point_undistort regression: pass");
        else
            $display("iterative_point_undistort regression: fail");
        $finish;
    end

endmodule
